// ===== design/w2s_pkg.sv =====
// Shared constants and types for the world-to-screen projection pipeline.
package w2s_pkg;

  localparam int SCREEN_WIDTH  = 1920;
  localparam int SCREEN_HEIGHT = 1080;
  localparam int DEPTH_ONE     = 16384;

  // Homogeneous w of an input point, 1.0 in Q15.8.
  localparam int P_ONE = 256;

  localparam int PW  = 24;          // world coordinate width
  localparam int EW  = 16;          // matrix entry width
  localparam int RW  = 4 * EW;      // packed matrix row width
  localparam int VW  = 42;          // view-space vector width
  localparam int HW  = VW / 2;      // half of a view-space value
  localparam int CW  = 59;          // clip-space vector width
  localparam int NW  = CW + 1;      // numerator and denominator width
  localparam int HN  = NW / 2;      // half of a numerator
  localparam int MW  = 15;          // screen scale factor width
  localparam int QW  = 16;          // result width
  localparam int AW  = NW + MW + 2; // biased dividend width

  localparam int NUM_REGS  = 8;
  localparam int ADDR_W    = 6;
  localparam int REG_VIEW0 = 0;
  localparam int REG_PROJ0 = 4;

  localparam int MV_LAT   = 2;
  localparam int DIV_LAT  = QW + 3;
  localparam int PIPE_LAT = 2 * MV_LAT + 1 + DIV_LAT;

  localparam logic signed [QW-1:0] Q_MIN      = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [QW-1:0] Q_MAX      = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] DEPTH_BACK = -QW'(DEPTH_ONE);

  typedef logic [RW-1:0] row_t;
  typedef row_t [3:0] mat_t;

  // Identity row: 1.0 in Q8.8 on the diagonal.
  function automatic row_t row_reset(input logic [1:0] r);
    row_reset = RW'(P_ONE) << (EW * int'(r));
  endfunction

endpackage

// ===== design/w2s_regs.sv =====
// APB register file holding the view and projection matrices.
module w2s_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [w2s_pkg::ADDR_W-1:0]  paddr,
  input  logic [w2s_pkg::RW-1:0]      pwdata,
  output logic [w2s_pkg::RW-1:0]      prdata,
  output logic                        pready,
  output w2s_pkg::mat_t               view_o,
  output w2s_pkg::mat_t               proj_o
);

  w2s_pkg::row_t rows_q [w2s_pkg::NUM_REGS];
  logic [2:0]    idx;

  assign idx    = paddr[w2s_pkg::ADDR_W-1:3];
  assign pready = 1'b1;
  assign prdata = rows_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < w2s_pkg::NUM_REGS; i++) begin
        rows_q[i] <= w2s_pkg::row_reset(2'(i));
      end
    end else if (psel && penable && pwrite) begin
      rows_q[idx] <= pwdata;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      view_o[r] = rows_q[w2s_pkg::REG_VIEW0 + r];
      proj_o[r] = rows_q[w2s_pkg::REG_PROJ0 + r];
    end
  end

endmodule

// ===== design/w2s_mvmul.sv =====
// Two-stage 4x4 matrix by vector multiplier with split partial products.
module w2s_mvmul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  w2s_pkg::mat_t                      mat_i,
  input  logic [3:0][w2s_pkg::VW-1:0]        vec_i,
  output logic [3:0][w2s_pkg::CW-1:0]        res_o
);

  localparam int PLW = w2s_pkg::EW + w2s_pkg::HW + 1;
  localparam int PHW = w2s_pkg::EW + w2s_pkg::HW;

  logic signed [PLW-1:0]         pl_d [4][4];
  logic signed [PHW-1:0]         ph_d [4][4];
  logic signed [PLW-1:0]         pl_q [4][4];
  logic signed [PHW-1:0]         ph_q [4][4];
  logic signed [w2s_pkg::CW-1:0] sum_d [4];
  logic signed [w2s_pkg::CW-1:0] sum_q [4];

  // Each vector element is cut into an unsigned low half and a signed high half.
  always_comb begin
    logic signed [w2s_pkg::EW-1:0] e;
    logic signed [w2s_pkg::HW:0]   lo;
    logic signed [w2s_pkg::HW-1:0] hi;
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        e  = signed'(mat_i[r][w2s_pkg::EW*k +: w2s_pkg::EW]);
        lo = signed'({1'b0, vec_i[k][w2s_pkg::HW-1:0]});
        hi = signed'(vec_i[k][w2s_pkg::VW-1:w2s_pkg::HW]);
        pl_d[r][k] = e * lo;
        ph_d[r][k] = e * hi;
      end
    end
  end

  always_comb begin
    logic signed [w2s_pkg::CW-1:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        acc = acc + (w2s_pkg::CW'(ph_q[r][k]) <<< w2s_pkg::HW) + w2s_pkg::CW'(pl_q[r][k]);
      end
      sum_d[r] = acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q  <= pl_d;
      ph_q  <= ph_d;
      sum_q <= sum_d;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      res_o[r] = sum_q[r];
    end
  end

endmodule

// ===== design/w2s_div.sv =====
// Pipelined floor(num * mul / den) saturated to 16 bits, one quotient bit per stage.
module w2s_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [w2s_pkg::NW-1:0]      num_i,
  input  logic [w2s_pkg::NW-1:0]             den_i,
  input  logic [w2s_pkg::MW-1:0]             mul_i,
  output logic signed [w2s_pkg::QW-1:0]      quot_o
);

  localparam int QW = w2s_pkg::QW;
  localparam int AW = w2s_pkg::AW;
  localparam int HN = w2s_pkg::HN;

  logic [HN+w2s_pkg::MW-1:0]        pl_q;
  logic signed [HN+w2s_pkg::MW:0]   ph_q;
  logic [w2s_pkg::NW-1:0]           d1_q;
  logic signed [AW-1:0]             a_d;
  logic signed [AW-1:0]             a_q;
  logic [w2s_pkg::NW-1:0]           d2_q;

  logic [AW-1:0]          rem_q [QW];
  logic [w2s_pkg::NW-1:0] d_q   [QW];
  logic [QW-1:0]          q_q   [QW+1];
  logic                   lo_q  [QW+1];
  logic                   hi_q  [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= num_i[HN-1:0] * mul_i;
      ph_q <= signed'(num_i[w2s_pkg::NW-1:HN]) * signed'({1'b0, mul_i});
      d1_q <= den_i;
    end
  end

  // Biasing by half the range makes the quotient unsigned.
  assign a_d = (signed'(AW'(ph_q)) <<< HN) + signed'(AW'(pl_q))
             + signed'(AW'(d1_q) << (QW - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_d;
      d2_q <= d1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= a_q;
      d_q[0]   <= d2_q;
      q_q[0]   <= '0;
      lo_q[0]  <= a_q[AW-1];
      hi_q[0]  <= !a_q[AW-1] && (AW'(unsigned'(a_q)) >= (AW'(d2_q) << QW));
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_bit
    logic [AW-1:0] shd;
    logic          take;
    assign shd  = AW'(d_q[k]) << (QW - 1 - k);
    assign take = rem_q[k] >= shd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k+1]  <= {q_q[k][QW-2:0], take};
        lo_q[k+1] <= lo_q[k];
        hi_q[k+1] <= hi_q[k];
      end
    end

    if (k < QW - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= take ? rem_q[k] - shd : rem_q[k];
          d_q[k+1]   <= d_q[k];
        end
      end
    end
  end

  always_comb begin
    if (lo_q[QW]) begin
      quot_o = w2s_pkg::Q_MIN;
    end else if (hi_q[QW]) begin
      quot_o = w2s_pkg::Q_MAX;
    end else begin
      quot_o = signed'(q_q[QW] ^ w2s_pkg::Q_MIN);
    end
  end

endmodule

// ===== design/world_to_screen_projection.sv =====
// Top level of the world-to-screen perspective projection pipeline.
//
//   Channel  Direction  Handshake                Payload
//   in       sink       in_valid_i / in_ready_o  world_x_i, world_y_i, world_z_i
//   out      source     out_valid_o/out_ready_i  screen_x_o, screen_y_o, depth_o,
//                                                behind_camera_o
//   cfg      APB slave  psel, penable, pready    paddr, pwdata, prdata (64 bits)
//
// A new transaction is taken every cycle while the output is not stalled.
// There are 25 register stages: two per matrix product, one for the divide
// operands, nineteen in each divider and the output register. The first loads
// at the accepting edge.
// The dividers produce one quotient bit per stage and set the latency.
// Reset clears the valid bits and loads both matrices with the identity.
// When the output register holds a transaction that is not taken, the whole
// pipeline freezes; nothing is lost or repeated.
module world_to_screen_projection (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [w2s_pkg::PW-1:0]      world_x_i,
  input  logic signed [w2s_pkg::PW-1:0]      world_y_i,
  input  logic signed [w2s_pkg::PW-1:0]      world_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [w2s_pkg::QW-1:0]      screen_x_o,
  output logic signed [w2s_pkg::QW-1:0]      screen_y_o,
  output logic signed [w2s_pkg::QW-1:0]      depth_o,
  output logic                               behind_camera_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [w2s_pkg::ADDR_W-1:0]         paddr,
  input  logic [w2s_pkg::RW-1:0]             pwdata,
  output logic [w2s_pkg::RW-1:0]             prdata,
  output logic                               pready
);

  localparam int NW = w2s_pkg::NW;

  w2s_pkg::mat_t                  view_mat;
  w2s_pkg::mat_t                  proj_mat;
  logic [3:0][w2s_pkg::VW-1:0]    pvec;
  logic [3:0][w2s_pkg::CW-1:0]    view_res;
  logic [3:0][w2s_pkg::VW-1:0]    vvec;
  logic [3:0][w2s_pkg::CW-1:0]    clip;
  logic                           en;
  logic [w2s_pkg::PIPE_LAT-1:0]   vld_q;
  logic                           beh_q [w2s_pkg::DIV_LAT+1];
  logic signed [NW-1:0]           nx_q, ny_q, nz_q;
  logic [NW-1:0]                  dx_q, dz_q;
  logic signed [w2s_pkg::QW-1:0]  qx, qy, qz;
  logic signed [w2s_pkg::CW-1:0]  c0, c1, c2, c3;
  logic                           out_valid_q;
  logic signed [w2s_pkg::QW-1:0]  sx_q, sy_q, dz_out_q;
  logic                           beh_out_q;

  w2s_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .view_o  (view_mat),
    .proj_o  (proj_mat)
  );

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign pvec[0] = w2s_pkg::VW'(world_x_i);
  assign pvec[1] = w2s_pkg::VW'(world_y_i);
  assign pvec[2] = w2s_pkg::VW'(world_z_i);
  assign pvec[3] = w2s_pkg::VW'(w2s_pkg::P_ONE);

  w2s_mvmul u_view (
    .clk_i (clk_i),
    .en_i  (en),
    .mat_i (view_mat),
    .vec_i (pvec),
    .res_o (view_res)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      vvec[k] = view_res[k][w2s_pkg::VW-1:0];
    end
  end

  w2s_mvmul u_proj (
    .clk_i (clk_i),
    .en_i  (en),
    .mat_i (proj_mat),
    .vec_i (vvec),
    .res_o (clip)
  );

  assign c0 = signed'(clip[0]);
  assign c1 = signed'(clip[1]);
  assign c2 = signed'(clip[2]);
  assign c3 = signed'(clip[3]);

  // Screen x uses (x + w) / 2w, screen y uses (w - y) / 2w, depth z / w.
  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q     <= NW'(c0) + NW'(c3);
      ny_q     <= NW'(c3) - NW'(c1);
      nz_q     <= NW'(c2);
      dx_q     <= unsigned'(NW'(c3) <<< 1);
      dz_q     <= unsigned'(NW'(c3));
      beh_q[0] <= c3[w2s_pkg::CW-1] || (c3 == '0);
      for (int i = 1; i <= w2s_pkg::DIV_LAT; i++) begin
        beh_q[i] <= beh_q[i-1];
      end
    end
  end

  w2s_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (nx_q),
    .den_i  (dx_q),
    .mul_i  (w2s_pkg::MW'(w2s_pkg::SCREEN_WIDTH)),
    .quot_o (qx)
  );

  w2s_div u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (ny_q),
    .den_i  (dx_q),
    .mul_i  (w2s_pkg::MW'(w2s_pkg::SCREEN_HEIGHT)),
    .quot_o (qy)
  );

  w2s_div u_div_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (nz_q),
    .den_i  (dz_q),
    .mul_i  (w2s_pkg::MW'(w2s_pkg::DEPTH_ONE)),
    .quot_o (qz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[w2s_pkg::PIPE_LAT-2:0], in_valid_i};
      out_valid_q <= vld_q[w2s_pkg::PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      beh_out_q <= beh_q[w2s_pkg::DIV_LAT];
      if (beh_q[w2s_pkg::DIV_LAT]) begin
        sx_q     <= '1;
        sy_q     <= '1;
        dz_out_q <= w2s_pkg::DEPTH_BACK;
      end else begin
        sx_q     <= qx;
        sy_q     <= qy;
        dz_out_q <= qz;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign screen_x_o      = sx_q;
  assign screen_y_o      = sy_q;
  assign depth_o         = dz_out_q;
  assign behind_camera_o = beh_out_q;

  a_behind_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && behind_camera_o |->
      screen_x_o == '1 && screen_y_o == '1 && depth_o == w2s_pkg::DEPTH_BACK)
    else $error("behind-camera transaction carries wrong values");

  a_tail_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[w2s_pkg::PIPE_LAT-1] |=> out_valid_o)
    else $error("transaction lost at the output register");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q) && out_valid_o)
    else $error("pipeline moved during a stall");

endmodule
